### sv/capacitated_route_split_cost_unit_assert.svh
// assertion macros for the route split cost unit
// used by capacitated_route_split_cost_unit, no other dependencies
`ifndef CAPACITATED_ROUTE_SPLIT_COST_UNIT_ASSERT_SVH
`define CAPACITATED_ROUTE_SPLIT_COST_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CRSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crsc: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define CRSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crsc: next-cycle check failed");

`endif

### sv/crsc_pkg.sv
// shared types and constants of the route split cost unit
// no dependencies
package crsc_pkg;

  localparam int CAP_W      = 24;
  localparam int WEIGHT_W   = 16;
  localparam int LOAD_W     = 25;
  localparam int RDIST_W    = 40;
  localparam int TOTAL_W    = 48;
  localparam int ROUTES_W   = 9;
  localparam int CUST_IN_W  = 8;
  localparam int IDX_IN_W   = 9;
  localparam int VALUE_W    = 32;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam int CCOUNT_W   = 9;

  localparam logic [LOAD_W-1:0]   LOAD_MAX   = {LOAD_W{1'b1}};
  localparam logic [RDIST_W-1:0]  RDIST_MAX  = {RDIST_W{1'b1}};
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = {TOTAL_W{1'b1}};
  localparam logic [ROUTES_W-1:0] ROUTES_MAX = {ROUTES_W{1'b1}};

  localparam logic [REQ_W-1:0] REQ_WEIGHT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DIST   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CUST   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUST_COUNT = 1'd1;

  localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 9'd256;

  typedef struct packed {
    logic exe;  // fold the current customer into the tour
    logic fin;  // close the last route and clear the tour
  } acc_ctrl_t;

endpackage

### sv/capacitated_route_split_cost_unit.sv
// top level of the route split cost unit: control, memory addressing, result register
// depends on crsc_pkg, crsc_ram, crsc_acc and capacitated_route_split_cost_unit_assert.svh
//
//  channel | direction | handshake        | fields
//  --------+-----------+------------------+-------------------------------------------
//  in_     | input     | in_valid/in_stall | req_type row_index col_index load_value
//          |           |                  | customer last_customer
//  out_    | output    | out_valid/out_stall | total_distance vehicle_count
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index cfg_data
//
// a customer passes the read and execute states: its transfer reads its weight and two
// distances on the two read ports of the distance ram, the read state reads the depot
// leg of the previous customer and the execute state updates the tour; a last customer
// goes on to the finish state, which closes the tour into the result register; reset
// clears the tour, the state and the capacity; memory contents stay undefined until loaded
// out_stall holds the result register; a new item is still taken unless a closing tour
// finds the result register full

`include "capacitated_route_split_cost_unit_assert.svh"

module capacitated_route_split_cost_unit #(
  parameter int MAX_CUSTOMERS = 256,
  parameter int DIST_WIDTH    = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [crsc_pkg::REQ_W-1:0]        in_req_type,
  input  logic [crsc_pkg::IDX_IN_W-1:0]     in_row_index,
  input  logic [crsc_pkg::IDX_IN_W-1:0]     in_col_index,
  input  logic [crsc_pkg::VALUE_W-1:0]      in_load_value,
  input  logic [crsc_pkg::CUST_IN_W-1:0]    in_customer,
  input  logic                              in_last_customer,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [crsc_pkg::TOTAL_W-1:0]      out_total_distance,
  output logic [crsc_pkg::ROUTES_W-1:0]     out_vehicle_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DIM   = MAX_CUSTOMERS + 1;
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_CUSTOMERS);
  localparam int DEP_W = $clog2(MAX_CUSTOMERS + 1);
  localparam int NCUST = 2 ** crsc_pkg::CUST_IN_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EXE  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  function automatic logic [AW-1:0] dist_addr(input logic [31:0] row, input logic [31:0] col);
    dist_addr = AW'(row * DIM + col);
  endfunction

  logic [1:0]                       state_r, state_nxt;
  logic [crsc_pkg::CAP_W-1:0]       capacity_r;
  logic [crsc_pkg::CCOUNT_W-1:0]    ccount_r;
  logic [CW-1:0]                    cust_r;
  logic                             last_r;
  logic [crsc_pkg::WEIGHT_W-1:0]    w_r;
  logic [DIST_WIDTH-1:0]            d_dep_cust_r, d_prev_cust_r;
  logic                             out_valid_r, out_valid_nxt;
  logic [crsc_pkg::TOTAL_W-1:0]     out_total_r;
  logic [crsc_pkg::ROUTES_W-1:0]    out_count_r;

  logic [CW-1:0]                    cust_mod_tbl [NCUST];
  logic [CW-1:0]                    cust_in;
  logic [DEP_W-1:0]                 dep_idx;
  logic [CW-1:0]                    prev_cust, prev_fwd;
  logic                             in_xfer, cust_xfer, out_free, can_take;
  logic                             dist_we, wt_we;
  logic [AW-1:0]                    dist_waddr, dist_ra, dist_rb;
  logic [DIST_WIDTH-1:0]            dist_qa, dist_qb;
  logic [crsc_pkg::WEIGHT_W-1:0]    wt_q;
  logic [CW-1:0]                    wt_waddr;
  crsc_pkg::acc_ctrl_t              acc_ctrl;
  logic [crsc_pkg::TOTAL_W-1:0]     res_total;
  logic [crsc_pkg::ROUTES_W-1:0]    res_count;

  // customer index reduced modulo the customer span, folded into a constant table
  for (genvar g = 0; g < NCUST; g++) begin : g_cust_mod
    assign cust_mod_tbl[g] = CW'(g % MAX_CUSTOMERS);
  end
  assign cust_in = cust_mod_tbl[in_customer];

  assign dep_idx = (32'(ccount_r) > MAX_CUSTOMERS) ? DEP_W'(MAX_CUSTOMERS)
                                                   : DEP_W'(ccount_r);

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  always_comb begin
    case (state_r)
      ST_IDLE: can_take = 1'b1;
      ST_RD:   can_take = 1'b0;
      ST_EXE:  can_take = !last_r;
      ST_FIN:  can_take = out_free;
      default: can_take = 1'b0;
    endcase
  end
  assign in_stall  = !can_take;
  assign in_xfer   = in_valid && can_take;
  assign cust_xfer = in_xfer && (in_req_type == crsc_pkg::REQ_CUST);
  assign cfg_ready = 1'b1;

  // memory writes land at the transfer edge, so a following read sees them
  assign dist_we    = in_xfer && (in_req_type == crsc_pkg::REQ_DIST)
                      && (32'(in_row_index) <= MAX_CUSTOMERS)
                      && (32'(in_col_index) <= MAX_CUSTOMERS);
  assign dist_waddr = dist_addr(32'(in_row_index), 32'(in_col_index));
  assign wt_we      = in_xfer && (in_req_type == crsc_pkg::REQ_WEIGHT)
                      && (32'(in_row_index) < MAX_CUSTOMERS);
  assign wt_waddr   = CW'(32'(in_row_index));

  // the tour update in EXE sets prev to the current customer at the same edge
  assign prev_fwd = (state_r == ST_EXE) ? cust_r : prev_cust;
  assign dist_ra  = (state_r == ST_RD) ? dist_addr(32'(dep_idx), 32'(prev_cust))
                                       : dist_addr(32'(dep_idx), 32'(cust_in));
  assign dist_rb  = dist_addr(32'(prev_fwd), 32'(cust_in));

  crsc_ram #(
    .WIDTH (DIST_WIDTH),
    .DEPTH (DEPTH)
  ) u_dist_ram (
    .clk       (clk),
    .wr_en     (dist_we),
    .wr_addr   (dist_waddr),
    .wr_data   (DIST_WIDTH'(in_load_value)),
    .rd_addr_a (dist_ra),
    .rd_data_a (dist_qa),
    .rd_addr_b (dist_rb),
    .rd_data_b (dist_qb)
  );

  crsc_ram #(
    .WIDTH (crsc_pkg::WEIGHT_W),
    .DEPTH (MAX_CUSTOMERS)
  ) u_wt_ram (
    .clk       (clk),
    .wr_en     (wt_we),
    .wr_addr   (wt_waddr),
    .wr_data   (crsc_pkg::WEIGHT_W'(in_load_value)),
    .rd_addr_a (cust_in),
    .rd_data_a (wt_q),
    .rd_addr_b (cust_in),
    .rd_data_b ()
  );

  assign acc_ctrl.exe = (state_r == ST_EXE);
  assign acc_ctrl.fin = (state_r == ST_FIN) && out_free;

  crsc_acc #(
    .DIST_WIDTH (DIST_WIDTH),
    .CUST_W     (CW)
  ) u_acc (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (acc_ctrl),
    .capacity      (capacity_r),
    .cust          (cust_r),
    .weight        (w_r),
    .d_dep_cust    (d_dep_cust_r),
    .d_prev_cust   (d_prev_cust_r),
    .d_dep_prev    (dist_qa),
    .prev_customer (prev_cust),
    .res_total     (res_total),
    .res_count     (res_count)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cust_xfer) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EXE;
      ST_EXE: begin
        if (last_r) state_nxt = ST_FIN;
        else if (cust_xfer) state_nxt = ST_RD;
        else state_nxt = ST_IDLE;
      end
      ST_FIN: begin
        if (out_free) state_nxt = cust_xfer ? ST_RD : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc_ctrl.fin) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      capacity_r  <= '0;
      ccount_r    <= crsc_pkg::CCOUNT_RESET;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          crsc_pkg::CFG_CAPACITY:   capacity_r <= cfg_data;
          crsc_pkg::CFG_CUST_COUNT: ccount_r   <= cfg_data[crsc_pkg::CCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (cust_xfer) last_r <= in_last_customer;
    end
  end

  always_ff @(posedge clk) begin
    if (cust_xfer) cust_r <= cust_in;
    if (state_r == ST_RD) begin
      w_r           <= wt_q;
      d_dep_cust_r  <= dist_qa;
      d_prev_cust_r <= dist_qb;
    end
    if (acc_ctrl.fin) begin
      out_total_r <= res_total;
      out_count_r <= res_count;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_total_distance = out_total_r;
  assign out_vehicle_count  = out_count_r;

  `CRSC_ASSERT_NEXT(a_rd_then_exe, clk, rst_n, state_r == ST_RD, state_r == ST_EXE)
  `CRSC_ASSERT_SAME(a_rd_blocks_input, clk, rst_n, state_r == ST_RD, in_stall)
  `CRSC_ASSERT_SAME(a_result_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_FIN))
  `CRSC_ASSERT_NEXT(a_fin_to_result, clk, rst_n, acc_ctrl.fin, out_valid_r)

endmodule

### sv/crsc_ram.sv
// generic ram: one write port, two read ports, registered read data
// no dependencies
module crsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### sv/crsc_acc.sv
// tour accumulator: route load, route distance, tour total, route count
// depends on crsc_pkg
module crsc_acc #(
  parameter int DIST_WIDTH = 32,
  parameter int CUST_W     = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  crsc_pkg::acc_ctrl_t            ctrl,
  input  logic [crsc_pkg::CAP_W-1:0]     capacity,
  input  logic [CUST_W-1:0]              cust,
  input  logic [crsc_pkg::WEIGHT_W-1:0]  weight,
  input  logic [DIST_WIDTH-1:0]          d_dep_cust,
  input  logic [DIST_WIDTH-1:0]          d_prev_cust,
  input  logic [DIST_WIDTH-1:0]          d_dep_prev,
  output logic [CUST_W-1:0]              prev_customer,
  output logic [crsc_pkg::TOTAL_W-1:0]   res_total,
  output logic [crsc_pkg::ROUTES_W-1:0]  res_count
);

  localparam int LW     = crsc_pkg::LOAD_W;
  localparam int RW     = crsc_pkg::RDIST_W;
  localparam int TW     = crsc_pkg::TOTAL_W;
  localparam int RSUM_W = ((DIST_WIDTH > RW) ? DIST_WIDTH : RW) + 1;
  localparam int TSUM_W = TW + 2;

  logic [LW-1:0]                     load_r, load_nxt;
  logic [RW-1:0]                     rdist_r, rdist_nxt;
  logic [TW-1:0]                     total_r, total_nxt;
  logic [crsc_pkg::ROUTES_W-1:0]     routes_r, routes_nxt;
  logic                              started_r, started_nxt;
  logic [CUST_W-1:0]                 prev_r, prev_nxt;

  logic [LW:0]       load_sum;
  logic              over;
  logic [RSUM_W-1:0] dep_leg, link_sum;
  logic [RW-1:0]     dep_leg_sat, link_sat;
  logic [TSUM_W-1:0] close_sum, fin_sum;
  logic [TW-1:0]     close_sat;

  assign load_sum = (LW+1)'(load_r) + (LW+1)'(weight);
  assign over     = load_sum > (LW+1)'(capacity);

  assign dep_leg     = RSUM_W'(d_dep_cust);
  assign dep_leg_sat = (dep_leg > RSUM_W'(crsc_pkg::RDIST_MAX)) ? crsc_pkg::RDIST_MAX
                                                                 : RW'(dep_leg);
  assign link_sum    = RSUM_W'(rdist_r) + RSUM_W'(d_prev_cust);
  assign link_sat    = (link_sum > RSUM_W'(crsc_pkg::RDIST_MAX)) ? crsc_pkg::RDIST_MAX
                                                                 : RW'(link_sum);

  // closing a full route adds its return leg to the depot
  assign close_sum = TSUM_W'(total_r) + TSUM_W'(rdist_r) + TSUM_W'(d_dep_prev);
  assign close_sat = (close_sum > TSUM_W'(crsc_pkg::TOTAL_MAX)) ? crsc_pkg::TOTAL_MAX
                                                                : TW'(close_sum);

  // after the last customer was folded in, prev is that customer
  assign fin_sum   = TSUM_W'(total_r) + TSUM_W'(rdist_r) + TSUM_W'(d_dep_cust);
  assign res_total = (fin_sum > TSUM_W'(crsc_pkg::TOTAL_MAX)) ? crsc_pkg::TOTAL_MAX
                                                              : TW'(fin_sum);
  assign res_count = routes_r;

  assign prev_customer = prev_r;

  always_comb begin
    load_nxt    = load_r;
    rdist_nxt   = rdist_r;
    total_nxt   = total_r;
    routes_nxt  = routes_r;
    started_nxt = started_r;
    prev_nxt    = prev_r;
    if (ctrl.exe) begin
      prev_nxt = cust;
      if (!started_r) begin
        load_nxt    = LW'(weight);
        rdist_nxt   = dep_leg_sat;
        routes_nxt  = crsc_pkg::ROUTES_W'(1);
        total_nxt   = '0;
        started_nxt = 1'b1;
      end else if (over) begin
        total_nxt = close_sat;
        load_nxt  = LW'(weight);
        rdist_nxt = dep_leg_sat;
        if (routes_r != crsc_pkg::ROUTES_MAX) begin
          routes_nxt = routes_r + crsc_pkg::ROUTES_W'(1);
        end
      end else begin
        load_nxt  = (load_sum > (LW+1)'(crsc_pkg::LOAD_MAX)) ? crsc_pkg::LOAD_MAX
                                                             : LW'(load_sum);
        rdist_nxt = link_sat;
      end
    end
    if (ctrl.fin) begin
      load_nxt    = '0;
      rdist_nxt   = '0;
      total_nxt   = '0;
      routes_nxt  = crsc_pkg::ROUTES_W'(1);
      started_nxt = 1'b0;
      prev_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r    <= '0;
      rdist_r   <= '0;
      total_r   <= '0;
      routes_r  <= crsc_pkg::ROUTES_W'(1);
      started_r <= 1'b0;
      prev_r    <= '0;
    end else begin
      load_r    <= load_nxt;
      rdist_r   <= rdist_nxt;
      total_r   <= total_nxt;
      routes_r  <= routes_nxt;
      started_r <= started_nxt;
      prev_r    <= prev_nxt;
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// testbench of capacitated_route_split_cost_unit: a directed table, then random phases of
// weight and distance loads then tours, each result checked against a table score or a tour scorer
// depends on crsc_pkg and capacitated_route_split_cost_unit
module tb;

  localparam logic [crsc_pkg::REQ_W-1:0] REQ_NONE = 2'd3;  // unknown request, dropped by the block
  localparam bit [crsc_pkg::CAP_W-1:0] CAP_TOP = {crsc_pkg::CAP_W{1'b1}};
  localparam int DEPOT_TOP     = 256;
  localparam int MATRIX_DIM    = DEPOT_TOP + 1;
  localparam int TARGET_ITEMS  = 1350;
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    bit [crsc_pkg::REQ_W-1:0]     req;
    bit [crsc_pkg::IDX_IN_W-1:0]  row;
    bit [crsc_pkg::IDX_IN_W-1:0]  col;
    bit [crsc_pkg::VALUE_W-1:0]   value;
    bit [crsc_pkg::CUST_IN_W-1:0] cust;
    bit                           last;
  } crsc_item_t;

  typedef struct {
    bit [crsc_pkg::TOTAL_W-1:0]  total;
    bit [crsc_pkg::ROUTES_W-1:0] routes;
  } score_t;

  typedef struct {
    crsc_item_t item;
    bit         typed;
    score_t     score;
  } table_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [crsc_pkg::REQ_W-1:0]      in_req_type;
  logic [crsc_pkg::IDX_IN_W-1:0]   in_row_index;
  logic [crsc_pkg::IDX_IN_W-1:0]   in_col_index;
  logic [crsc_pkg::VALUE_W-1:0]    in_load_value;
  logic [crsc_pkg::CUST_IN_W-1:0]  in_customer;
  logic                            in_last_customer;
  logic                            out_valid;
  logic                            out_stall;
  logic [crsc_pkg::TOTAL_W-1:0]    out_total_distance;
  logic [crsc_pkg::ROUTES_W-1:0]   out_vehicle_count;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [crsc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [crsc_pkg::CFG_DATA_W-1:0] cfg_data;

  capacitated_route_split_cost_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_row_index       (in_row_index),
    .in_col_index       (in_col_index),
    .in_load_value      (in_load_value),
    .in_customer        (in_customer),
    .in_last_customer   (in_last_customer),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_total_distance (out_total_distance),
    .out_vehicle_count  (out_vehicle_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // scorer state
  bit [31:0]                    dist_mem [int];
  bit [crsc_pkg::WEIGHT_W-1:0]  weight_mem [256];
  bit [crsc_pkg::LOAD_W-1:0]    route_load;
  bit [crsc_pkg::RDIST_W-1:0]   route_len;
  bit [crsc_pkg::TOTAL_W-1:0]   tour_sum;
  bit [crsc_pkg::ROUTES_W-1:0]  routes_open;
  bit [crsc_pkg::CUST_IN_W-1:0] prev_cust;
  bit                           tour_open;
  bit [crsc_pkg::CAP_W-1:0]     capacity;
  bit [crsc_pkg::CCOUNT_W-1:0]  cust_count;

  table_row_t rows[$];
  score_t pending_scores[$];
  int     mismatches;
  int     items_sent;
  bit     no_gaps;
  bit     quiet;
  bit     hold_req;

  function automatic bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b, bit [63:0] limit);
    bit [63:0] s;
    s = a + b;
    return (s > limit) ? limit : s;
  endfunction

  function automatic bit [63:0] leg(int r, int c);
    if (r > DEPOT_TOP || c > DEPOT_TOP) return 0;
    if (!dist_mem.exists(r * MATRIX_DIM + c)) return 0;
    return dist_mem[r * MATRIX_DIM + c];
  endfunction

  function automatic void clear_tour();
    route_load  = '0;
    route_len   = '0;
    tour_sum    = '0;
    routes_open = 9'd1;
    prev_cust   = '0;
    tour_open   = 1'b0;
  endfunction

  // folds one accepted item into the scorer, returns 1 when it closes a tour
  function automatic bit score_item(input crsc_item_t it, output score_t sc);
    int depot;
    int cust;
    int r;
    int c;
    bit [63:0] w;
    bit [63:0] closed;
    sc = '{total: '0, routes: '0};
    r = it.row;
    c = it.col;
    case (it.req)
      crsc_pkg::REQ_WEIGHT: begin
        if (r < DEPOT_TOP) weight_mem[r] = it.value[crsc_pkg::WEIGHT_W-1:0];
        return 1'b0;
      end
      crsc_pkg::REQ_DIST: begin
        if (r <= DEPOT_TOP && c <= DEPOT_TOP) dist_mem[r * MATRIX_DIM + c] = it.value;
        return 1'b0;
      end
      crsc_pkg::REQ_CUST: ;
      default: return 1'b0;
    endcase
    depot = (cust_count > DEPOT_TOP) ? DEPOT_TOP : cust_count;
    cust  = it.cust;
    w     = weight_mem[cust];
    if (!tour_open) begin
      route_load  = crsc_pkg::LOAD_W'(w);
      route_len   = crsc_pkg::RDIST_W'(sat_sum(leg(depot, cust), 0, crsc_pkg::RDIST_MAX));
      routes_open = 9'd1;
      tour_sum    = '0;
      tour_open   = 1'b1;
    end else if (route_load + w > capacity) begin
      closed      = route_len + leg(depot, prev_cust);
      tour_sum    = crsc_pkg::TOTAL_W'(sat_sum(tour_sum, closed, crsc_pkg::TOTAL_MAX));
      route_load  = crsc_pkg::LOAD_W'(w);
      route_len   = crsc_pkg::RDIST_W'(sat_sum(leg(depot, cust), 0, crsc_pkg::RDIST_MAX));
      if (routes_open < crsc_pkg::ROUTES_MAX) routes_open++;
    end else begin
      route_load = crsc_pkg::LOAD_W'(sat_sum(route_load, w, crsc_pkg::LOAD_MAX));
      route_len  = crsc_pkg::RDIST_W'(sat_sum(route_len, leg(prev_cust, cust),
                                              crsc_pkg::RDIST_MAX));
    end
    prev_cust = crsc_pkg::CUST_IN_W'(cust);
    if (!it.last) return 1'b0;
    closed    = route_len + leg(depot, cust);
    sc.total  = crsc_pkg::TOTAL_W'(sat_sum(tour_sum, closed, crsc_pkg::TOTAL_MAX));
    sc.routes = routes_open;
    clear_tour();
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic bit [crsc_pkg::VALUE_W-1:0] pick_dist();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2, 3, 4: return $urandom_range(0, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic crsc_item_t mk(bit [crsc_pkg::REQ_W-1:0] req,
                                    bit [crsc_pkg::IDX_IN_W-1:0] row,
                                    bit [crsc_pkg::IDX_IN_W-1:0] col,
                                    bit [crsc_pkg::VALUE_W-1:0] value,
                                    bit [crsc_pkg::CUST_IN_W-1:0] cust, bit last);
    crsc_item_t it;
    it.req   = req;
    it.row   = row;
    it.col   = col;
    it.value = value;
    it.cust  = cust;
    it.last  = last;
    return it;
  endfunction

  function automatic void add_row(input crsc_item_t item, input bit typed,
                                  input score_t score);
    rows.insert(rows.size(), '{item, typed, score});
  endfunction

  // all fields random; callers override the ones that matter
  function automatic crsc_item_t rnd_item();
    return mk(crsc_pkg::REQ_W'($urandom), crsc_pkg::IDX_IN_W'($urandom),
              crsc_pkg::IDX_IN_W'($urandom), $urandom,
              crsc_pkg::CUST_IN_W'($urandom), 1'($urandom));
  endfunction

  task automatic send_item(input crsc_item_t it, input bit typed, input score_t typed_score);
    int gap;
    bit done;
    score_t sc;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type      = it.req;
    in_row_index     = it.row;
    in_col_index     = it.col;
    in_load_value    = it.value;
    in_customer      = it.cust;
    in_last_customer = it.last;
    in_valid         = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    done = score_item(it, sc);
    if (done) pending_scores.insert(pending_scores.size(), typed ? typed_score : sc);
    @(negedge clk);
  endtask

  task automatic send(input crsc_item_t it);
    send_item(it, 1'b0, '{total: '0, routes: '0});
  endtask

  // wait for every result, then let the last load or customer drain out
  task automatic drain();
    in_valid = 1'b0;
    while (pending_scores.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input bit [crsc_pkg::CAP_W-1:0] cap,
                            input bit [crsc_pkg::CCOUNT_W-1:0] count);
    cfg_index = crsc_pkg::CFG_CAPACITY;
    cfg_data  = cap;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    capacity = cap;
    @(negedge clk);
    cfg_index = crsc_pkg::CFG_CUST_COUNT;
    cfg_data  = {(crsc_pkg::CFG_DATA_W-crsc_pkg::CCOUNT_W)'($urandom), count};
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cust_count = count;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stall runs, quiet stretches, and one long hold on request
  initial begin
    int run;
    out_stall = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (run > 0) begin
        run--;
      end else if (quiet) begin
        out_stall = 1'b0;
      end else begin
        run = pick_gap();
        out_stall = (run > 0);
      end
    end
  end

  always @(posedge clk) begin
    score_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_scores.size() == 0) begin
        $error("result with nothing pending: total_distance %0h vehicle_count %0d",
               out_total_distance, out_vehicle_count);
        mismatches++;
      end else begin
        want = pending_scores.pop_front();
        if (out_total_distance !== want.total) begin
          $error("total_distance: expected %0h, got %0h", want.total, out_total_distance);
          mismatches++;
        end
        if (out_vehicle_count !== want.routes) begin
          $error("vehicle_count: expected %0d, got %0d", want.routes, out_vehicle_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    crsc_item_t it;
    int members[$];
    int nodes[$];
    int phase;
    int n;
    int depot;
    int ntours;
    int len;
    int wtop;
    bit [crsc_pkg::CAP_W-1:0] cap;
    bit [crsc_pkg::CCOUNT_W-1:0] cnt;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_req_type      = crsc_pkg::REQ_WEIGHT;
    in_row_index     = '0;
    in_col_index     = '0;
    in_load_value    = '0;
    in_customer      = '0;
    in_last_customer = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = crsc_pkg::CFG_CAPACITY;
    cfg_data         = '0;
    mismatches       = 0;
    items_sent       = 0;
    no_gaps          = 1'b0;
    quiet            = 1'b0;
    hold_req         = 1'b0;
    clear_tour();
    capacity   = '0;
    cust_count = crsc_pkg::CCOUNT_RESET;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // after reset: capacity 0, depot at 256; customers 0 and 255 only
    add_row(mk(crsc_pkg::REQ_WEIGHT, 9'd0, 9'd0, 32'hFFFF_FFFF, 8'd0, 1'b1), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_WEIGHT, 9'd255, 9'd0, 32'hABCD_0000, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_DIST, 9'd256, 9'd0, 32'h0001_0000, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_DIST, 9'd256, 9'd255, 32'hFFFF_FFFF, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_DIST, 9'd0, 9'd0, 32'd3, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_DIST, 9'd0, 9'd255, 32'd7, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_DIST, 9'd255, 9'd0, 32'h0002_0000, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_DIST, 9'd255, 9'd255, 32'd1, 8'd0, 1'b0), 1'b0, '{0, 0});
    // unknown request and out of range loads change nothing
    add_row(mk(REQ_NONE, 9'd256, 9'd256, 32'hFFFF_FFFF, 8'd255, 1'b1), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_WEIGHT, 9'd256, 9'd0, 32'h0000_1234, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_DIST, 9'd257, 9'd0, 32'h1234_5678, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_DIST, 9'd0, 9'd511, 32'h1234_5678, 8'd0, 1'b0), 1'b0, '{0, 0});
    // single customer tours, the second one heavier than the capacity
    add_row(mk(crsc_pkg::REQ_CUST, 9'd0, 9'd0, 32'd0, 8'd255, 1'b1), 1'b1,
            '{48'h0001_FFFF_FFFE, 9'd1});
    add_row(mk(crsc_pkg::REQ_CUST, 9'd0, 9'd0, 32'd0, 8'd0, 1'b1), 1'b1,
            '{48'h0000_0002_0000, 9'd1});
    // capacity 0 splits every customer into a route of its own
    add_row(mk(crsc_pkg::REQ_CUST, 9'd0, 9'd0, 32'd0, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_CUST, 9'd0, 9'd0, 32'd0, 8'd255, 1'b1), 1'b1,
            '{48'h0002_0001_FFFE, 9'd2});
    add_row(mk(crsc_pkg::REQ_CUST, 9'd0, 9'd0, 32'd0, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_CUST, 9'd0, 9'd0, 32'd0, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_CUST, 9'd0, 9'd0, 32'd0, 8'd255, 1'b1), 1'b1,
            '{48'h0002_0003_FFFE, 9'd3});
    add_row(mk(crsc_pkg::REQ_DIST, 9'd0, 9'd255, 32'd0, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_CUST, 9'd0, 9'd0, 32'd0, 8'd255, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_CUST, 9'd0, 9'd0, 32'd0, 8'd0, 1'b0), 1'b0, '{0, 0});
    add_row(mk(crsc_pkg::REQ_CUST, 9'd0, 9'd0, 32'd0, 8'd255, 1'b1), 1'b0, '{0, 0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].score);

    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      phase++;
      drain();
      quiet   = ($urandom_range(0, 3) == 0);
      no_gaps = quiet;
      wtop    = $urandom_range(0, 1) ? 16'hFFFF : $urandom_range(1, 2000);
      if (phase == 1) begin
        cap = CAP_TOP;
        cnt = 9'd256;
      end else if (phase == 2) begin
        cap = '0;
        cnt = 9'd1;
      end else begin
        case ($urandom_range(0, 5))
          0:       cap = '0;
          1:       cap = CAP_TOP;
          default: cap = crsc_pkg::CAP_W'($urandom_range(0, wtop * 3));
        endcase
        case ($urandom_range(0, 9))
          0:       cnt = 9'd256;
          1:       cnt = 9'd1;
          2:       cnt = 9'd0;
          3:       cnt = crsc_pkg::CCOUNT_W'($urandom_range(257, 511));
          default: cnt = crsc_pkg::CCOUNT_W'($urandom_range(1, 256));
        endcase
      end
      set_config(cap, cnt);
      depot = (cnt > DEPOT_TOP) ? DEPOT_TOP : cnt;

      // customer 0 stays in every set: it is the previous customer after a tour closes
      n = $urandom_range(2, 6);
      members = {0};
      repeat (n - 1) members.insert(members.size(), $urandom_range(0, 255));
      nodes = members;
      nodes.insert(nodes.size(), depot);

      foreach (members[i]) begin
        it = rnd_item();
        it.req   = crsc_pkg::REQ_WEIGHT;
        it.row   = crsc_pkg::IDX_IN_W'(members[i]);
        it.value = {16'($urandom), 16'($urandom_range(0, wtop))};
        send(it);
        items_sent++;
      end
      foreach (nodes[r]) begin
        foreach (nodes[c]) begin
          it = rnd_item();
          it.req   = crsc_pkg::REQ_DIST;
          it.row   = crsc_pkg::IDX_IN_W'(nodes[r]);
          it.col   = crsc_pkg::IDX_IN_W'(nodes[c]);
          it.value = pick_dist();
          send(it);
          items_sent++;
        end
      end

      // one phase offers short tours back to back while the receiver holds off
      if (phase == 3) begin
        no_gaps  = 1'b1;
        hold_req = 1'b1;
      end
      ntours = $urandom_range(8, 16);
      repeat (ntours) begin
        if (phase == 3) len = $urandom_range(1, 2);
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(9, 20);
        else len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            it = rnd_item();
            case ($urandom_range(0, 3))
              0: it.req = REQ_NONE;
              1: begin
                it.req = crsc_pkg::REQ_WEIGHT;
                it.row = crsc_pkg::IDX_IN_W'($urandom_range(256, 511));
              end
              2: begin
                it.req = crsc_pkg::REQ_DIST;
                if ($urandom_range(0, 1)) begin
                  it.row = crsc_pkg::IDX_IN_W'($urandom_range(257, 511));
                end else begin
                  it.col = crsc_pkg::IDX_IN_W'($urandom_range(257, 511));
                end
              end
              default: begin
                // legal reload in the middle of a tour
                if ($urandom_range(0, 1)) begin
                  it.req   = crsc_pkg::REQ_WEIGHT;
                  it.row   = crsc_pkg::IDX_IN_W'(members[$urandom_range(0, members.size() - 1)]);
                end else begin
                  it.req   = crsc_pkg::REQ_DIST;
                  it.row   = crsc_pkg::IDX_IN_W'(nodes[$urandom_range(0, nodes.size() - 1)]);
                  it.col   = crsc_pkg::IDX_IN_W'(nodes[$urandom_range(0, nodes.size() - 1)]);
                  it.value = pick_dist();
                end
              end
            endcase
            send(it);
            items_sent++;
          end
          it = rnd_item();
          it.req  = crsc_pkg::REQ_CUST;
          it.cust = crsc_pkg::CUST_IN_W'(members[$urandom_range(0, members.size() - 1)]);
          it.last = (k == len - 1);
          send(it);
          items_sent++;
        end
      end
      no_gaps = quiet;
    end

    drain();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### capacitated_route_split_cost_unit.f
+incdir+sv
sv/crsc_pkg.sv
sv/crsc_ram.sv
sv/crsc_acc.sv
sv/capacitated_route_split_cost_unit.sv
sim/tb.sv
